@@ hdl/bfth_pkg.sv @@
// Shared constants for the three-hash Bloom filter.
package bfth_pkg;

  localparam int HASH_W = 64;
  localparam int CHAR_W = 8;
  localparam int BCNT_W = 13;
  localparam int HALF_W = HASH_W / 2;

  localparam logic [HASH_W-1:0] RS_START = 64'd63689;
  localparam logic [HALF_W-1:0] RS_STEP = 32'd378551;
  localparam logic [BCNT_W-1:0] BCNT_RESET = 13'd50;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

@@ hdl/bfth_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bfth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bfth_fifo.sv @@
// Small register queue between the hashing front and the store back end.
module bfth_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/bfth_front.sv @@
// Hashing front end: folds each key character into the three string hashes.
module bfth_front #(
  parameter int MAX_BITS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [bfth_pkg::CHAR_W-1:0]   in_key_char,
  input  logic                          in_last_char,
  input  logic [bfth_pkg::BCNT_W-1:0]   bit_count,
  input  logic                          clearing,
  input  logic                          fifo_full,
  output logic                          push,
  output logic [1+3*bfth_pkg::HASH_W+$clog2(MAX_BITS+1)-1:0] push_data
);

  import bfth_pkg::*;

  localparam int MW   = $clog2(MAX_BITS + 1);
  localparam int CMPW = (MW > BCNT_W) ? MW : BCNT_W;

  typedef enum logic {F_IDLE, F_MUL} fstate_t;

  fstate_t          state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [HASH_W-1:0] h131_r, h131_nxt;
  logic [HASH_W-1:0] h65599_r, h65599_nxt;
  logic [HASH_W-1:0] hrs_r, hrs_nxt;
  logic [HASH_W-1:0] rsm_r, rsm_nxt;
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [HASH_W-1:0] c_r, c_nxt;
  logic              last_r, last_nxt;
  logic              kind_r, kind_nxt;
  logic [HALF_W-1:0] opa, opb;
  logic [HASH_W-1:0] prod, prod_hi;
  logic [HASH_W-1:0] c_ext;
  logic              accept;
  logic [MW-1:0]     modulus;

  assign in_stall = (state_r != F_IDLE) || clearing || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign c_ext    = {{(HASH_W - CHAR_W){in_key_char[CHAR_W-1]}}, in_key_char};

  // zero means one, above the store size saturates
  always_comb begin
    if (bit_count == '0) begin
      modulus = MW'(1);
    end else if (CMPW'(bit_count) > CMPW'(MAX_BITS)) begin
      modulus = MW'(MAX_BITS);
    end else begin
      modulus = MW'(bit_count);
    end
  end

  // shared 32x32 multiplier, operands picked per step
  always_comb begin
    case (step_r)
      3'd0:    begin opa = hrs_r[HALF_W-1:0];      opb = rsm_r[HALF_W-1:0];      end
      3'd1:    begin opa = hrs_r[HALF_W-1:0];      opb = rsm_r[HASH_W-1:HALF_W]; end
      3'd2:    begin opa = hrs_r[HASH_W-1:HALF_W]; opb = rsm_r[HALF_W-1:0];      end
      3'd3:    begin opa = rsm_r[HALF_W-1:0];      opb = RS_STEP;                end
      default: begin opa = rsm_r[HASH_W-1:HALF_W]; opb = RS_STEP;                end
    endcase
  end

  assign prod    = HASH_W'(opa) * HASH_W'(opb);
  assign prod_hi = {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    h131_nxt   = h131_r;
    h65599_nxt = h65599_r;
    hrs_nxt    = hrs_r;
    rsm_nxt    = rsm_r;
    acc_nxt    = acc_r;
    c_nxt      = c_r;
    last_nxt   = last_r;
    kind_nxt   = kind_r;
    push       = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          h131_nxt   = (h131_r << 7) + (h131_r << 1) + h131_r + c_ext;
          h65599_nxt = (h65599_r << 16) + (h65599_r << 6) - h65599_r + c_ext;
          c_nxt      = c_ext;
          last_nxt   = in_last_char;
          kind_nxt   = in_kind;
          step_nxt   = 3'd0;
          state_nxt  = F_MUL;
        end
      end
      F_MUL: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0:    acc_nxt = prod;
          3'd1:    acc_nxt = acc_r + prod_hi;
          3'd2:    hrs_nxt = acc_r + prod_hi + c_r;
          3'd3:    acc_nxt = prod;
          default: begin
            state_nxt = F_IDLE;
            if (last_r) begin
              push       = 1'b1;
              h131_nxt   = '0;
              h65599_nxt = '0;
              hrs_nxt    = '0;
              rsm_nxt    = RS_START;
            end else begin
              rsm_nxt = acc_r + prod_hi;
            end
          end
        endcase
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_data = {kind_r, h131_r, h65599_r, hrs_r, modulus};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      step_r   <= '0;
      h131_r   <= '0;
      h65599_r <= '0;
      hrs_r    <= '0;
      rsm_r    <= RS_START;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      h131_r   <= h131_nxt;
      h65599_r <= h65599_nxt;
      hrs_r    <= hrs_nxt;
      rsm_r    <= rsm_nxt;
    end
    acc_r  <= acc_nxt;
    c_r    <= c_nxt;
    last_r <= last_nxt;
    kind_r <= kind_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !clearing && !fifo_full)
    else $error("request accepted while clearing or queue full");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("key pushed into a full queue");
`endif

endmodule

@@ hdl/bfth_back.sv @@
// Store back end: remainder lanes, bit store access and result register.
module bfth_back #(
  parameter int MAX_BITS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fifo_empty,
  input  logic [1+3*bfth_pkg::HASH_W+$clog2(MAX_BITS+1)-1:0] fifo_data,
  output logic pop,
  output logic clearing,
  output logic out_valid,
  input  logic out_stall,
  output logic out_maybe_present
);

  import bfth_pkg::*;

  localparam int MW    = $clog2(MAX_BITS + 1);
  localparam int IW    = $clog2(MAX_BITS);
  localparam int WORDS = (MAX_BITS + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNTW  = $clog2(HASH_W);

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_DIV, B_RD, B_CHK, B_OUT} bstate_t;

  bstate_t           state_r, state_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [HASH_W-1:0] dvd_r [3];
  logic [HASH_W-1:0] dvd_nxt [3];
  logic [MW-1:0]     rem_r [3];
  logic [MW-1:0]     rem_nxt [3];
  logic [MW:0]       rem_sh [3];
  logic [MW-1:0]     m_r, m_nxt;
  logic              kind_r, kind_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_mp_r, out_mp_nxt;
  logic [IW-1:0]     idx;
  logic [AW-1:0]     word;
  logic [4:0]        pos;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [31:0]       wdata, rdata;

  assign idx   = IW'(rem_r[k_r]);
  assign word  = AW'(idx >> 5);
  assign pos   = idx[4:0];
  assign clearing = (state_r == B_CLR);
  assign pop   = (state_r == B_IDLE) && !fifo_empty;

  bfth_ram #(.WIDTH(32), .DEPTH(WORDS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (word),
    .rdata (rdata)
  );

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l] = {rem_r[l], dvd_r[l][HASH_W-1]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    kind_nxt      = kind_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    clr_nxt       = clr_r;
    out_mp_nxt    = out_mp_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = word;
    wdata         = rdata | (32'd1 << pos);
    for (int l = 0; l < 3; l++) begin
      dvd_nxt[l] = dvd_r[l];
      rem_nxt[l] = rem_r[l];
    end
    case (state_r)
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = B_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      B_IDLE: begin
        if (!fifo_empty) begin
          kind_nxt   = fifo_data[3*HASH_W+MW];
          dvd_nxt[0] = fifo_data[3*HASH_W+MW-1 -: HASH_W];
          dvd_nxt[1] = fifo_data[2*HASH_W+MW-1 -: HASH_W];
          dvd_nxt[2] = fifo_data[HASH_W+MW-1 -: HASH_W];
          m_nxt      = fifo_data[MW-1:0];
          for (int l = 0; l < 3; l++) begin
            rem_nxt[l] = '0;
          end
          cnt_nxt   = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        // one restoring remainder bit per lane per cycle
        for (int l = 0; l < 3; l++) begin
          if (rem_sh[l] >= {1'b0, m_r}) begin
            rem_nxt[l] = MW'(rem_sh[l] - {1'b0, m_r});
          end else begin
            rem_nxt[l] = MW'(rem_sh[l]);
          end
          dvd_nxt[l] = dvd_r[l] << 1;
        end
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(HASH_W - 1)) begin
          k_nxt     = 2'd0;
          hit_nxt   = 1'b1;
          state_nxt = B_RD;
        end
      end
      B_RD: state_nxt = B_CHK;
      B_CHK: begin
        if (kind_r == KIND_INSERT) begin
          we = 1'b1;
        end else begin
          hit_nxt = hit_r && rdata[pos];
        end
        if (k_r == 2'd2) begin
          state_nxt = (kind_r == KIND_QUERY) ? B_OUT : B_IDLE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = B_RD;
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_mp_nxt    = hit_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r    <= cnt_nxt;
    m_r      <= m_nxt;
    kind_r   <= kind_nxt;
    k_r      <= k_nxt;
    hit_r    <= hit_nxt;
    out_mp_r <= out_mp_nxt;
    for (int l = 0; l < 3; l++) begin
      dvd_r[l] <= dvd_nxt[l];
      rem_r[l] <= rem_nxt[l];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

`ifndef SYNTHESIS
  a_we_legal: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == B_CLR) || ((state_r == B_CHK) && (kind_r == KIND_INSERT)))
    else $error("store written outside clear or insert");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD) |-> (rem_r[0] < m_r) && (rem_r[1] < m_r) && (rem_r[2] < m_r))
    else $error("remainder not below modulus");
`endif

endmodule

@@ hdl/bloom_filter_three_hash.sv @@
// Top level of the three-hash Bloom filter.
//
// Keys arrive one character per request with a kind (insert or query) and a
// last-character flag; only the kind on the last character counts. The front
// end takes a new character only once it is through with the last one: it
// accepts it and folds it into the multiply-by-131 and multiply-by-65599
// hashes, then makes five passes through a single shared 32x32 multiplier for
// the RS hash and its running multiplier. A finished key goes into a two-entry
// queue, so the front carries on with the next key while the back end works.
// The back end runs a radix-2 remainder (three lanes in parallel) per key,
// then a read state and a check state per index on the bit-store RAM port,
// plus a state that loads the result register of a query. Inserts give no
// result; each query gives one maybe_present result. After reset a clearing
// pass zeroes the store, one 32-bit word a cycle, during which no request is
// accepted; configuration writes are taken at any time.
module bloom_filter_three_hash #(
  parameter int MAX_BITS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfth_pkg::BCNT_W-1:0] cfg_bit_count,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [bfth_pkg::CHAR_W-1:0] in_key_char,
  input  logic                        in_last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_maybe_present
);

  import bfth_pkg::*;

  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int QW = 1 + 3 * HASH_W + MW;

  logic [BCNT_W-1:0] bit_count_r;
  logic              clearing;
  logic              fifo_full, fifo_empty;
  logic              push, pop;
  logic [QW-1:0]     push_data, pop_data;

  // bit count register; a key takes the value in force when it is queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= BCNT_RESET;
    end else if (cfg_we) begin
      bit_count_r <= cfg_bit_count;
    end
  end

  bfth_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key_char  (in_key_char),
    .in_last_char (in_last_char),
    .bit_count    (bit_count_r),
    .clearing     (clearing),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_data    (push_data)
  );

  // finished keys: kind, three hashes, modulus
  bfth_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  bfth_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_empty        (fifo_empty),
    .fifo_data         (pop_data),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_maybe_present (out_maybe_present)
  );

endmodule
